// ===== rtl/core/lus_pkg.sv =====
`timescale 1ns / 1ps
package lus_pkg;

  localparam int QW   = 32;            // Q16.16 word
  localparam int FRAC = 16;            // fraction bits
  localparam int SW   = 2*QW - FRAC + 1; // widest pre-saturation value

  typedef logic signed [QW-1:0]   q_t;
  typedef logic signed [2*QW-1:0] prod_t;
  typedef logic signed [SW-1:0]   wide_t;

  localparam q_t    Q_MAX   = {1'b0, {(QW-1){1'b1}}};
  localparam q_t    Q_MIN   = {1'b1, {(QW-1){1'b0}}};
  localparam wide_t W_MAX   = {{(SW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam wide_t W_MIN   = {{(SW-QW+1){1'b1}}, {(QW-1){1'b0}}};
  localparam int    DIV_STAGES = QW;   // one quotient bit per stage

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_PIVOT = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_t;

  typedef struct packed {
    q_t a00; q_t a01; q_t a02;
    q_t a10; q_t a11; q_t a12;
    q_t a20; q_t a21; q_t a22;
    q_t b0;  q_t b1;  q_t b2;
  } in_t;

  typedef struct packed {
    q_t      x0;
    q_t      x1;
    q_t      x2;
    status_t status;
  } out_t;

  typedef struct packed {
    logic ovf;
    q_t   v;
  } qres_t;

  // Everything one system carries down the back-end pipeline.
  typedef struct packed {
    q_t a00; q_t a01; q_t a02;
    q_t a10; q_t a11; q_t a12;
    q_t a20; q_t a21; q_t a22;
    q_t b0;  q_t b1;  q_t b2;
    q_t l10; q_t l20; q_t l21;
    q_t u11; q_t u12; q_t u22;
    q_t w;   q_t z;   q_t y1;  q_t y2;
    q_t x1;  q_t x2;  q_t n;
    prod_t p0; prod_t p1; prod_t p2; prod_t p3; prod_t p4; prod_t p5;
    logic ovf;
    logic zp;
  } ctx_t;

  function automatic qres_t q_sat(input wide_t v);
    qres_t r;
    r.ovf = 1'b0;
    r.v   = v[QW-1:0];
    if (v > W_MAX) begin
      r.ovf = 1'b1;
      r.v   = Q_MAX;
    end else if (v < W_MIN) begin
      r.ovf = 1'b1;
      r.v   = Q_MIN;
    end
    return r;
  endfunction

  // Full product / 2^16, truncated toward zero, saturated.
  function automatic qres_t q_mul_fin(input prod_t p);
    prod_t adj;
    adj = p[2*QW-1] ? p + prod_t'((1 << FRAC) - 1) : p;
    return q_sat(SW'(adj >>> FRAC));
  endfunction

  function automatic qres_t q_sub(input q_t a, input q_t b);
    logic signed [QW:0] d;
    d = (QW+1)'(a) - (QW+1)'(b);
    return q_sat(SW'(d));
  endfunction

  function automatic prod_t q_mul(input q_t a, input q_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

// ===== rtl/core/solve_3x3_linear_system_core.sv =====
`timescale 1ns / 1ps
// 3x3 linear system solver, signed Q16.16 (Doolittle LU, no pivoting).
// Input channel: in_valid / in_stall / in_data carries one system (A, b).
// Result channel: out_valid / out_stall / out_data gives x0..x2 and status
// (ok, zero pivot with all x forced to zero, or saturation overflow).
// Throughput: one transaction per cycle, sustained, with no stall applied.
// Each system passes from the queue through five 33-stage pipelined dividers
// (l10/l20, l21, x2, x1, x0), twelve registered stages between them
// (divider capture, multiply, subtract) and the output register.
// A two-entry queue sits between the front end and the back-end pipeline,
// so in_stall depends only on queue occupancy.
// When the receiver stalls with a result waiting, the whole back-end
// pipeline holds; the queue then fills and in_stall rises.
// Reset (rst_n low, synchronous) empties the queue and clears all valid
// bits; no result is presented until new transactions arrive.
module solve_3x3_linear_system_core import lus_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_stall,
  output logic out_valid,
  output out_t out_data,
  input  logic out_stall
);

  logic q_valid;
  logic q_pop;
  ctx_t q_ctx;

  // front: accept, flag zero a00, queue
  lus_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .q_valid(q_valid), .q_ctx(q_ctx), .q_pop(q_pop)
  );

  // back: factor, substitute, hold result
  lus_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ctx(q_ctx), .q_pop(q_pop),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // a zero pivot always comes out with a zero solution
  a_zero_pivot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ZERO_PIVOT) |->
      (out_data.x0 == '0) && (out_data.x1 == '0) && (out_data.x2 == '0))
    else $error("zero pivot result with nonzero solution");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // queue must have room again once the back end drains it
  a_queue_frees: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall && !out_valid |=> !in_stall)
    else $error("input stalled while back end is free");

endmodule

// ===== rtl/core/lus_div.sv =====
`timescale 1ns / 1ps
// Pipelined Q16.16 divider, one quotient bit per stage, carries a context.
module lus_div import lus_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  q_t    num,
  input  q_t    den,
  input  ctx_t  ctx_in,
  output logic  out_valid,
  output qres_t quo,
  output ctx_t  ctx_out
);

  typedef struct packed {
    logic [QW-1:0] rem;
    logic [QW-1:0] sh;
    logic [QW-1:0] q;
    logic [QW-1:0] dm;
    logic          neg;
    logic          dz;
    logic          big;
  } dstg_t;

  localparam logic [QW-1:0] MIN_MAG = QW'(1) << (QW-1);

  function automatic dstg_t div_step(input dstg_t s);
    dstg_t r;
    logic [QW:0] trial;
    r     = s;
    trial = {s.rem, s.sh[QW-1]};
    r.sh  = {s.sh[QW-2:0], 1'b0};
    if (trial >= {1'b0, s.dm}) begin
      r.rem = QW'(trial - {1'b0, s.dm});
      r.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      r.rem = trial[QW-1:0];
      r.q   = {s.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  dstg_t st_r  [0:DIV_STAGES];
  ctx_t  ctx_r [0:DIV_STAGES];
  logic [DIV_STAGES:0] v_r;

  dstg_t         prep;
  logic [QW-1:0] nm;
  logic [QW-1:0] dm;

  always_comb begin
    nm        = num[QW-1] ? (~QW'(num) + 1'b1) : QW'(num);
    dm        = den[QW-1] ? (~QW'(den) + 1'b1) : QW'(den);
    prep.neg  = num[QW-1] ^ den[QW-1];
    prep.dz   = (den == '0);
    // quotient would need more than QW magnitude bits
    prep.big  = !prep.dz && ({{FRAC{1'b0}}, nm} >= {dm, {FRAC{1'b0}}});
    prep.rem  = nm >> FRAC;
    prep.sh   = nm << FRAC;
    prep.q    = '0;
    prep.dm   = dm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= prep;
      ctx_r[0] <= ctx_in;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]  <= div_step(st_r[k]);
        ctx_r[k+1] <= ctx_r[k];
      end
    end
  end

  dstg_t fin;
  assign fin = st_r[DIV_STAGES];

  always_comb begin
    quo.ovf = 1'b0;
    quo.v   = q_t'(fin.q);
    if (fin.dz) begin
      quo.v = '0;
    end else if (fin.big) begin
      quo.ovf = 1'b1;
      quo.v   = fin.neg ? Q_MIN : Q_MAX;
    end else if (fin.neg) begin
      if (fin.q > MIN_MAG) begin
        quo.ovf = 1'b1;
        quo.v   = Q_MIN;
      end else begin
        quo.v = q_t'(~fin.q + 1'b1);
      end
    end else if (fin.q[QW-1]) begin
      quo.ovf = 1'b1;
      quo.v   = Q_MAX;
    end
  end

  assign out_valid = v_r[DIV_STAGES];
  assign ctx_out   = ctx_r[DIV_STAGES];

endmodule

// ===== rtl/core/lus_front.sv =====
`timescale 1ns / 1ps
// Input side: takes transactions, flags a zero a00, two-entry queue to the back end.
module lus_front import lus_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_stall,
  output logic q_valid,
  output ctx_t q_ctx,
  input  logic q_pop
);

  ctx_t       mem_r [0:1];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  ctx_t       cls;

  always_comb begin
    cls     = '0;
    cls.a00 = in_data.a00; cls.a01 = in_data.a01; cls.a02 = in_data.a02;
    cls.a10 = in_data.a10; cls.a11 = in_data.a11; cls.a12 = in_data.a12;
    cls.a20 = in_data.a20; cls.a21 = in_data.a21; cls.a22 = in_data.a22;
    cls.b0  = in_data.b0;  cls.b1  = in_data.b1;  cls.b2  = in_data.b2;
    cls.zp  = (in_data.a00 == '0);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_ctx    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/lus_back.sv =====
`timescale 1ns / 1ps
// Back end: LU factor, substitution, result register. Whole pipe moves on en.
module lus_back import lus_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  ctx_t q_ctx,
  output logic q_pop,
  output logic out_valid,
  output out_t out_data,
  input  logic out_stall
);

  logic en;
  logic out_valid_r;
  out_t out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // l10, l20
  logic  va, vc, vd, ve, vf;
  qres_t qa, qb, qc, qd, qe, qf;
  ctx_t  ca, cc, cd, ce, cf;

  lus_div u_div_l10 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
    .num(q_ctx.a10), .den(q_ctx.a00), .ctx_in(q_ctx),
    .out_valid(va), .quo(qa), .ctx_out(ca)
  );

  lus_div u_div_l20 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
    .num(q_ctx.a20), .den(q_ctx.a00), .ctx_in('0),
    .out_valid(), .quo(qb), .ctx_out()
  );

  ctx_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r, c8_r, c9_r, c10_r, c11_r, c12_r;
  ctx_t c1_nxt, c2_nxt, c3_nxt, c4_nxt, c5_nxt, c6_nxt, c7_nxt, c8_nxt, c9_nxt;
  ctx_t c10_nxt, c11_nxt, c12_nxt;
  logic [12:1] v_r;
  out_t res;

  always_comb begin
    c1_nxt     = ca;
    c1_nxt.l10 = qa.v;
    c1_nxt.l20 = qb.v;
    c1_nxt.ovf = ca.ovf | qa.ovf | qb.ovf;
  end

  always_comb begin
    c2_nxt    = c1_r;
    c2_nxt.p0 = q_mul(c1_r.l10, c1_r.a01);
    c2_nxt.p1 = q_mul(c1_r.a01, c1_r.l20);
    c2_nxt.p2 = q_mul(c1_r.l10, c1_r.a02);
    c2_nxt.p3 = q_mul(c1_r.l20, c1_r.a02);
    c2_nxt.p4 = q_mul(c1_r.b0,  c1_r.l10);
    c2_nxt.p5 = q_mul(c1_r.b0,  c1_r.l20);
  end

  always_comb begin
    qres_t m0, m1, m2, m3, m4, m5, s0, s1, s2, s3, s4, s5;
    m0 = q_mul_fin(c2_r.p0); m1 = q_mul_fin(c2_r.p1); m2 = q_mul_fin(c2_r.p2);
    m3 = q_mul_fin(c2_r.p3); m4 = q_mul_fin(c2_r.p4); m5 = q_mul_fin(c2_r.p5);
    s0 = q_sub(c2_r.a11, m0.v);
    s1 = q_sub(c2_r.a21, m1.v);
    s2 = q_sub(c2_r.a12, m2.v);
    s3 = q_sub(c2_r.a22, m3.v);
    s4 = q_sub(c2_r.b1,  m4.v);
    s5 = q_sub(c2_r.b2,  m5.v);
    c3_nxt     = c2_r;
    c3_nxt.u11 = s0.v;
    c3_nxt.n   = s1.v;
    c3_nxt.u12 = s2.v;
    c3_nxt.w   = s3.v;
    c3_nxt.y1  = s4.v;
    c3_nxt.z   = s5.v;
    c3_nxt.zp  = c2_r.zp | (s0.v == '0);
    c3_nxt.ovf = c2_r.ovf | m0.ovf | m1.ovf | m2.ovf | m3.ovf | m4.ovf | m5.ovf
               | s0.ovf | s1.ovf | s2.ovf | s3.ovf | s4.ovf | s5.ovf;
  end

  // l21
  lus_div u_div_l21 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_r[3]),
    .num(c3_r.n), .den(c3_r.u11), .ctx_in(c3_r),
    .out_valid(vc), .quo(qc), .ctx_out(cc)
  );

  always_comb begin
    c4_nxt     = cc;
    c4_nxt.l21 = qc.v;
    c4_nxt.ovf = cc.ovf | qc.ovf;
  end

  always_comb begin
    c5_nxt    = c4_r;
    c5_nxt.p0 = q_mul(c4_r.l21, c4_r.u12);
    c5_nxt.p1 = q_mul(c4_r.y1,  c4_r.l21);
  end

  always_comb begin
    qres_t m0, m1, s0, s1;
    m0 = q_mul_fin(c5_r.p0);
    m1 = q_mul_fin(c5_r.p1);
    s0 = q_sub(c5_r.w, m0.v);
    s1 = q_sub(c5_r.z, m1.v);
    c6_nxt     = c5_r;
    c6_nxt.u22 = s0.v;
    c6_nxt.y2  = s1.v;
    c6_nxt.zp  = c5_r.zp | (s0.v == '0);
    c6_nxt.ovf = c5_r.ovf | m0.ovf | m1.ovf | s0.ovf | s1.ovf;
  end

  // x2
  lus_div u_div_x2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_r[6]),
    .num(c6_r.y2), .den(c6_r.u22), .ctx_in(c6_r),
    .out_valid(vd), .quo(qd), .ctx_out(cd)
  );

  always_comb begin
    c7_nxt     = cd;
    c7_nxt.x2  = qd.v;
    c7_nxt.ovf = cd.ovf | qd.ovf;
  end

  always_comb begin
    c8_nxt    = c7_r;
    c8_nxt.p0 = q_mul(c7_r.u12, c7_r.x2);
    c8_nxt.p1 = q_mul(c7_r.a02, c7_r.x2);
  end

  always_comb begin
    qres_t m0, s0;
    m0 = q_mul_fin(c8_r.p0);
    s0 = q_sub(c8_r.y1, m0.v);
    c9_nxt     = c8_r;
    c9_nxt.n   = s0.v;
    c9_nxt.ovf = c8_r.ovf | m0.ovf | s0.ovf;
  end

  // x1
  lus_div u_div_x1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_r[9]),
    .num(c9_r.n), .den(c9_r.u11), .ctx_in(c9_r),
    .out_valid(ve), .quo(qe), .ctx_out(ce)
  );

  always_comb begin
    c10_nxt     = ce;
    c10_nxt.x1  = qe.v;
    c10_nxt.ovf = ce.ovf | qe.ovf;
  end

  always_comb begin
    c11_nxt    = c10_r;
    c11_nxt.p0 = q_mul(c10_r.a01, c10_r.x1);
  end

  always_comb begin
    qres_t m0, m1, s0, s1;
    m0 = q_mul_fin(c11_r.p0);
    m1 = q_mul_fin(c11_r.p1);
    s0 = q_sub(c11_r.b0, m0.v);
    s1 = q_sub(s0.v, m1.v);
    c12_nxt     = c11_r;
    c12_nxt.n   = s1.v;
    c12_nxt.ovf = c11_r.ovf | m0.ovf | m1.ovf | s0.ovf | s1.ovf;
  end

  // x0
  lus_div u_div_x0 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_r[12]),
    .num(c12_r.n), .den(c12_r.a00), .ctx_in(c12_r),
    .out_valid(vf), .quo(qf), .ctx_out(cf)
  );

  always_comb begin
    res.x0 = qf.v;
    res.x1 = cf.x1;
    res.x2 = cf.x2;
    if (cf.zp) begin
      res.x0     = '0;
      res.x1     = '0;
      res.x2     = '0;
      res.status = ST_ZERO_PIVOT;
    end else if (cf.ovf | qf.ovf) begin
      res.status = ST_OVERFLOW;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c1_nxt;  c2_r  <= c2_nxt;  c3_r  <= c3_nxt;
      c4_r  <= c4_nxt;  c5_r  <= c5_nxt;  c6_r  <= c6_nxt;
      c7_r  <= c7_nxt;  c8_r  <= c8_nxt;  c9_r  <= c9_nxt;
      c10_r <= c10_nxt; c11_r <= c11_nxt; c12_r <= c12_nxt;
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[1]  <= va;    v_r[2]  <= v_r[1];  v_r[3]  <= v_r[2];
      v_r[4]  <= vc;    v_r[5]  <= v_r[4];  v_r[6]  <= v_r[5];
      v_r[7]  <= vd;    v_r[8]  <= v_r[7];  v_r[9]  <= v_r[8];
      v_r[10] <= ve;    v_r[11] <= v_r[10]; v_r[12] <= v_r[11];
      out_valid_r <= vf;
    end
  end

endmodule

// ===== test/tb_solve_3x3_linear_system_core.sv =====
`timescale 1ns / 1ps
// Testbench for the 3x3 LU solver core.
// Stimulus goes through one send task; a monitor process compares every
// result transaction with the oldest predicted solution. The predictor does
// the same fixed-point steps as the block, in 64-bit integer arithmetic.
module tb_solve_3x3_linear_system_core;
  import lus_pkg::*;

  localparam int DRAIN_CYCLES = 400;   // well past the pipeline latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  logic out_stall = 1'b0;

  out_t solutions_q[$];
  int   n_errors = 0;
  bit   sender_gaps = 1'b1;     // random idle cycles on the input side
  bit   receiver_gaps = 1'b1;   // random stall cycles on the output side
  int   hold_cycles = 0;        // long receiver hold-off, counted down below

  always #5 clk = ~clk;

  solve_3x3_linear_system_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // ---- fixed-point predictor ----
  bit ovf_seen;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      ovf_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // SV integer division truncates toward zero, as required
  function automatic longint fx_mul(longint a, longint b);
    return clamp32((a * b) / 65536);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    if (d == 0) return 0;
    return clamp32((n * 65536) / d);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp32(a - b);
  endfunction

  function automatic out_t solve_system(in_t s);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2;
    longint l10, l20, l21, u11, u12, u22, y1, y2, x0, x1, x2;
    out_t r;
    a00 = s.a00; a01 = s.a01; a02 = s.a02;
    a10 = s.a10; a11 = s.a11; a12 = s.a12;
    a20 = s.a20; a21 = s.a21; a22 = s.a22;
    b0 = s.b0; b1 = s.b1; b2 = s.b2;
    ovf_seen = 1'b0;
    l10 = fx_div(a10, a00);
    l20 = fx_div(a20, a00);
    u11 = fx_sub(a11, fx_mul(l10, a01));
    l21 = fx_div(fx_sub(a21, fx_mul(a01, l20)), u11);
    u12 = fx_sub(a12, fx_mul(l10, a02));
    u22 = fx_sub(fx_sub(a22, fx_mul(l20, a02)), fx_mul(l21, u12));
    y1 = fx_sub(b1, fx_mul(b0, l10));
    y2 = fx_sub(fx_sub(b2, fx_mul(b0, l20)), fx_mul(y1, l21));
    x2 = fx_div(y2, u22);
    x1 = fx_div(fx_sub(y1, fx_mul(u12, x2)), u11);
    x0 = fx_div(fx_sub(fx_sub(b0, fx_mul(a01, x1)), fx_mul(a02, x2)), a00);
    r.x0 = q_t'(x0);
    r.x1 = q_t'(x1);
    r.x2 = q_t'(x2);
    if (a00 == 0 || u11 == 0 || u22 == 0) begin
      // zero pivot wins over overflow; solution forced to zero
      r.x0 = '0;
      r.x1 = '0;
      r.x2 = '0;
      r.status = ST_ZERO_PIVOT;
    end else if (ovf_seen) begin
      r.status = ST_OVERFLOW;
    end else begin
      r.status = ST_OK;
    end
    return r;
  endfunction

  // ---- sender: one transaction, with random idle gaps first ----
  task automatic send_system(in_t s);
    while (sender_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    solutions_q.push_back(solve_system(s));
    // valid is left high; the next call or the caller lowers it
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---- receiver stall generator ----
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_gaps && ($urandom_range(99) < 36);
    end
  end

  // ---- result checker ----
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (solutions_q.size() == 0) begin
        $error("result with no pending system: x0=%h x1=%h x2=%h status=%0d",
               out_data.x0, out_data.x1, out_data.x2, out_data.status);
        n_errors++;
      end else begin
        exp_r = solutions_q.pop_front();
        if (out_data.x0 !== exp_r.x0) begin
          $error("x0 expected %h actual %h", exp_r.x0, out_data.x0);
          n_errors++;
        end
        if (out_data.x1 !== exp_r.x1) begin
          $error("x1 expected %h actual %h", exp_r.x1, out_data.x1);
          n_errors++;
        end
        if (out_data.x2 !== exp_r.x2) begin
          $error("x2 expected %h actual %h", exp_r.x2, out_data.x2);
          n_errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          n_errors++;
        end
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic q_t rand_word();
    case ($urandom_range(7))
      0: return q_t'($urandom);
      1: return Q_MAX;
      2: return Q_MIN;
      3: return '0;
      4, 5: return q_t'($signed($urandom_range(8 << 16)) - (4 << 16));
      default: return q_t'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic in_t rand_system();
    in_t s;
    s.a00 = rand_word(); s.a01 = rand_word(); s.a02 = rand_word();
    s.a10 = rand_word(); s.a11 = rand_word(); s.a12 = rand_word();
    s.a20 = rand_word(); s.a21 = rand_word(); s.a22 = rand_word();
    s.b0 = rand_word(); s.b1 = rand_word(); s.b2 = rand_word();
    return s;
  endfunction

  // well-conditioned: diagonally dominant, moderate values, ok status likely
  function automatic in_t tame_system();
    in_t s;
    s = rand_system();
    s.a01 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a02 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a10 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a12 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a20 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a21 = q_t'($signed($urandom_range(4 << 16)) - (2 << 16));
    s.a00 = q_t'(($urandom_range(1) ? 1 : -1) * $signed($urandom_range(16 << 16, 6 << 16)));
    s.a11 = q_t'(($urandom_range(1) ? 1 : -1) * $signed($urandom_range(16 << 16, 6 << 16)));
    s.a22 = q_t'(($urandom_range(1) ? 1 : -1) * $signed($urandom_range(16 << 16, 6 << 16)));
    return s;
  endfunction

  function automatic in_t identity_system(q_t b0, q_t b1, q_t b2);
    in_t s;
    s = '0;
    s.a00 = 32'sh0001_0000;
    s.a11 = 32'sh0001_0000;
    s.a22 = 32'sh0001_0000;
    s.b0 = b0; s.b1 = b1; s.b2 = b2;
    return s;
  endfunction

  task automatic wait_drained();
    while (solutions_q.size() != 0) @(posedge clk);
  endtask

  // ---- tests ----
  task automatic test_directed();
    in_t s;
    send_system(identity_system(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000));
    send_system(identity_system(Q_MAX, Q_MIN, '0));
    send_system(identity_system(32'sh0000_0001, -32'sh0000_0001, 32'sh7FFF_0000));
    // zero pivots: a00, then u11, then u22
    s = identity_system(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    s.a00 = '0;
    send_system(s);
    s = identity_system(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    s.a11 = '0;
    send_system(s);
    s = identity_system(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    s.a22 = '0;
    send_system(s);
    // singular but with nonzero a11: u11 cancels to zero
    s = identity_system(32'sh0001_0000, 32'sh0002_0000, '0);
    s.a01 = 32'sh0002_0000; s.a10 = 32'sh0001_0000; s.a11 = 32'sh0002_0000;
    send_system(s);
    // overflow: tiny pivot, huge rhs
    s = identity_system(Q_MAX, Q_MAX, Q_MAX);
    s.a00 = 32'sh0000_0001;
    send_system(s);
    // overflow in subtraction
    s = identity_system(Q_MIN, Q_MAX, Q_MIN);
    s.a10 = Q_MIN; s.a01 = Q_MAX;
    send_system(s);
    // all fields at the extremes
    send_system('{default: Q_MAX});
    send_system('{default: Q_MIN});
    send_system('{default: 32'sh0000_0001});
    send_system('{default: 32'shFFFF_FFFF});
    s = '{default: Q_MIN};
    s.a00 = 32'shFFFF_FFFF;
    send_system(s);
    // all-zero input: zero pivot
    send_system('0);
    for (int i = 0; i < 6; i++) send_system(tame_system());
    finish_burst();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) send_system(tame_system());
      else send_system(rand_system());
    end
    finish_burst();
  endtask

  // back-to-back with no gaps on either side
  task automatic test_full_rate(int count);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    for (int i = 0; i < count; i++) send_system(tame_system());
    finish_burst();
    wait_drained();
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure(int count);
    sender_gaps = 1'b0;
    hold_cycles = 600;
    for (int i = 0; i < count; i++) send_system(rand_system());
    finish_burst();
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_full_rate(200);
    test_backpressure(250);
    test_random(180);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && solutions_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
